/* rtl/core/point_polar_filter_min_binning_assert.svh */
// Assertion macros for the polar point filter.
`ifndef POINT_POLAR_FILTER_MIN_BINNING_ASSERT_SVH
`define POINT_POLAR_FILTER_MIN_BINNING_ASSERT_SVH
`ifndef SYNTHESIS
`define PPF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PPF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PPF_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PPF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/ppf_pkg.sv */
package ppf_pkg;
  localparam int CW = 20;
  localparam int RW = 20;
  localparam int BIW = 10;
  localparam int ZW = 34;
  localparam int MAX_BINS = 1024;

  localparam logic [2:0] REG_MIN_RANGE = 3'd0;
  localparam logic [2:0] REG_MAX_RANGE = 3'd1;
  localparam logic [2:0] REG_MIN_X     = 3'd2;
  localparam logic [2:0] REG_MAX_X     = 3'd3;
  localparam logic [2:0] REG_MIN_Y     = 3'd4;
  localparam logic [2:0] REG_MAX_Y     = 3'd5;
  localparam logic [2:0] REG_BIN_COUNT = 3'd6;
  localparam logic [2:0] REG_OUT_MODE  = 3'd7;

  // Work item handed from the front end to the back end.
  typedef struct packed {
    logic            cmd;
    logic [BIW-1:0]  read_index;
    logic            pass;
    logic [RW-1:0]   range;
    logic [BIW-1:0]  bin;
  } job_t;

  // Arctangent table in binary angle units, 2^32 per turn.
  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0: v = 32'h20000000;  5'd1: v = 32'h12E4051E;  5'd2: v = 32'h09FB385B;
      5'd3: v = 32'h051111D4;  5'd4: v = 32'h028B0D43;  5'd5: v = 32'h0145D7E1;
      5'd6: v = 32'h00A2F61E;  5'd7: v = 32'h00517C55;  5'd8: v = 32'h0028BE53;
      5'd9: v = 32'h00145F2F;  5'd10: v = 32'h000A2F98; 5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6; 5'd13: v = 32'h000145F3; 5'd14: v = 32'h0000A2F9;
      5'd15: v = 32'h0000517C; 5'd16: v = 32'h000028BE; 5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A2F; 5'd19: v = 32'h00000517; 5'd20: v = 32'h0000028B;
      5'd21: v = 32'h00000145; 5'd22: v = 32'h000000A2; 5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction
endpackage

/* rtl/core/ppf_front.sv */
module ppf_front import ppf_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            cmd,
  input  logic signed [CW-1:0] px, py, ox, oy,
  input  logic [BIW-1:0]  read_index,
  input  logic [RW-1:0]   min_range, max_range,
  input  logic signed [CW-1:0] min_x, max_x, min_y, max_y,
  input  logic [10:0]     bin_count,
  output logic            job_valid,
  input  logic            job_ready,
  output job_t            job
);
  localparam logic [2:0] S_IDLE = 3'd0, S_SQRT = 3'd1, S_CORD = 3'd2,
                         S_MUL = 3'd3, S_BIN = 3'd4, S_DONE = 3'd5;
  localparam int XW = CW + 28;

  logic [2:0] state_r, state_nxt;
  logic signed [CW:0] dx_r, dy_r;
  logic [5:0] step_r;
  logic [41:0] rem_r, root_r;
  logic [41:0] bit_r;
  logic signed [XW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r;
  logic fixed_r;
  logic [32:0] ph_r;
  logic [10:0] cnt_r;
  logic [43:0] prod_r;
  job_t job_r;

  assign in_ready = (state_r == S_IDLE);
  assign job_valid = (state_r == S_DONE);
  assign job = job_r;

  logic signed [CW:0] dx_w, dy_w;
  logic [CW:0] ax_w, ay_w;
  logic [41:0] sum_w;
  assign dx_w = {px[CW-1], px} - {ox[CW-1], ox};
  assign dy_w = {py[CW-1], py} - {oy[CW-1], oy};
  assign ax_w = dx_w[CW] ? -dx_w : dx_w;
  assign ay_w = dy_w[CW] ? -dy_w : dy_w;
  assign sum_w = 42'(ax_w) * 42'(ax_w) + 42'(ay_w) * 42'(ay_w);

  logic [41:0] rb_w;
  logic signed [XW-1:0] sx_w, sy_w;
  assign rb_w = root_r + bit_r;
  assign sx_w = x_r >>> step_r;
  assign sy_w = y_r >>> step_r;

  logic signed [ZW-1:0] zp_w;
  logic [32:0] ph_w;
  assign zp_w = z_r + ZW'(64'sh80000000);
  assign ph_w = zp_w[ZW-1] ? 33'd0 : (zp_w > ZW'(64'h100000000)) ? 33'h100000000
              : zp_w[32:0];

  // Bin index from the product; S_BIN limits it to the last bin.
  logic [11:0] binr_w;
  assign binr_w = prod_r[43:32];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = cmd ? S_DONE : S_SQRT;
      S_SQRT: if (bit_r == 42'd1) state_nxt = S_CORD;
      S_CORD: if (fixed_r || step_r == 6'(CORDIC_STEPS - 1)) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_BIN;
      S_BIN:  state_nxt = S_DONE;
      S_DONE: if (job_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath: integer square root two bits a cycle, then CORDIC one step a cycle.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: if (in_valid) begin
        dx_r <= dx_w; dy_r <= dy_w;
        rem_r <= sum_w; root_r <= '0; bit_r <= 42'h1 << 40;
        step_r <= '0;
        cnt_r <= (bin_count < 11'd2) ? 11'd2 :
                 (bin_count > 11'(MAX_BINS)) ? 11'(MAX_BINS) : bin_count;
        job_r.cmd <= cmd; job_r.read_index <= read_index;
        job_r.pass <= 1'b0; job_r.range <= '0; job_r.bin <= '0;
        // Zero offset and the angle of plus pi skip the CORDIC.
        if (dx_w == 0 && dy_w == 0) begin
          fixed_r <= 1'b1; ph_r <= 33'h80000000;
        end else if (dy_w == 0 && dx_w[CW]) begin
          fixed_r <= 1'b1; ph_r <= 33'h100000000;
        end else begin
          fixed_r <= 1'b0;
        end
        if (dx_w[CW]) begin
          if (!dy_w[CW]) begin
            x_r <= XW'(dy_w) <<< 24; y_r <= -(XW'(dx_w) <<< 24);
            z_r <= ZW'(64'sh40000000);
          end else begin
            x_r <= -(XW'(dy_w) <<< 24); y_r <= XW'(dx_w) <<< 24;
            z_r <= -ZW'(64'sh40000000);
          end
        end else begin
          x_r <= XW'(dx_w) <<< 24; y_r <= XW'(dy_w) <<< 24; z_r <= '0;
        end
      end
      S_SQRT: begin
        if (rem_r >= rb_w) begin
          rem_r <= rem_r - rb_w; root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      S_CORD: begin
        if (!fixed_r) begin
          if (!y_r[XW-1]) begin
            x_r <= x_r + sy_w; y_r <= y_r - sx_w;
            z_r <= z_r + ZW'(atan_lut(step_r[4:0]));
          end else begin
            x_r <= x_r - sy_w; y_r <= y_r + sx_w;
            z_r <= z_r - ZW'(atan_lut(step_r[4:0]));
          end
        end
        step_r <= step_r + 6'd1;
        job_r.range <= (root_r > 42'(2**RW - 1)) ? RW'(2**RW - 1) : root_r[RW-1:0];
        job_r.pass <= (dx_r > $signed({min_x[CW-1], min_x})) &&
                      (dx_r < $signed({max_x[CW-1], max_x})) &&
                      (dy_r > $signed({min_y[CW-1], min_y})) &&
                      (dy_r < $signed({max_y[CW-1], max_y})) &&
                      (root_r > 42'(min_range)) && (root_r < 42'(max_range));
      end
      S_MUL: begin
        prod_r <= 44'((fixed_r ? ph_r : ph_w)) * 44'(cnt_r);
      end
      S_BIN: begin
        job_r.bin <= (binr_w >= 12'(cnt_r)) ? BIW'(cnt_r - 11'd1) : binr_w[BIW-1:0];
      end
      default: ;
    endcase
  end
endmodule

/* rtl/core/ppf_queue.sv */
module ppf_queue import ppf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  job_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output job_t rd_data
);
  // Two-entry queue between front and back end.
  job_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic wr_fire, rd_fire;
  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data = mem_r[rp_r];
  assign wr_fire = wr_valid && wr_ready;
  assign rd_fire = rd_valid && rd_ready;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (wr_fire) wp_r <= ~wp_r;
      if (rd_fire) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_fire) - 2'(rd_fire);
    end
  end
  always_ff @(posedge clk) begin
    if (wr_fire) mem_r[wp_r] <= wr_data;
  end
endmodule

/* rtl/core/ppf_back.sv */
module ppf_back import ppf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic job_valid,
  output logic job_ready,
  input  job_t job,
  input  logic [1:0] output_mode,
  output logic out_valid,
  input  logic out_ready,
  output logic [51:0] out_data
);
  localparam int AW = $clog2(MAX_BINS);
  localparam logic [2:0] B_IDLE = 3'd0, B_READ = 3'd1, B_WRITE = 3'd2, B_OUT = 3'd3,
                         B_CLEAR = 3'd4;
  logic [2:0] st_r;
  // Each entry holds the filled flag above the stored minimum range.
  logic [RW:0] mem [MAX_BINS];
  logic [RW:0] rd_r;
  logic [AW-1:0] clr_r;
  job_t j_r;
  logic [AW-1:0] addr_w;
  logic in_rng_w;
  logic upd_w;
  logic wr_en_w;
  logic [AW-1:0] wr_addr_w;
  logic [RW:0] wr_data_w;
  logic [51:0] out_r;

  assign job_ready = (st_r == B_IDLE);
  assign out_valid = (st_r == B_OUT);
  assign out_data = out_r;
  assign addr_w = j_r.cmd ? AW'(j_r.read_index) : AW'(j_r.bin);
  assign in_rng_w = j_r.cmd ? (32'(j_r.read_index) < MAX_BINS) : (32'(j_r.bin) < MAX_BINS);

  // A passing point lowers its bin when binning is on and the bin is empty or larger.
  assign upd_w = !j_r.cmd && j_r.pass && output_mode[1] && in_rng_w &&
                 (!rd_r[RW] || j_r.range < rd_r[RW-1:0]);

  // One write port: the clearing pass after reset, then bin clears and updates.
  assign wr_en_w = (st_r == B_CLEAR) ||
                   (st_r == B_WRITE && ((j_r.cmd && in_rng_w) || upd_w));
  assign wr_addr_w = (st_r == B_CLEAR) ? clr_r : addr_w;
  assign wr_data_w = (st_r == B_WRITE && upd_w) ? {1'b1, j_r.range} : '0;

  // Sequencing of one request; after reset every bin is emptied, one per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_CLEAR; clr_r <= '0;
    end else begin
      case (st_r)
        B_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(MAX_BINS - 1)) st_r <= B_IDLE;
        end
        B_IDLE: if (job_valid) st_r <= B_READ;
        B_READ: st_r <= B_WRITE;
        B_WRITE: st_r <= B_OUT;
        B_OUT: if (out_ready) st_r <= B_IDLE;
        default: st_r <= B_IDLE;
      endcase
    end
  end

  // Read-modify-write of one bin per request.
  always_ff @(posedge clk) begin
    if (st_r == B_IDLE && job_valid) j_r <= job;
    if (st_r == B_READ) rd_r <= mem[addr_w];
    if (wr_en_w) mem[wr_addr_w] <= wr_data_w;
    if (st_r == B_WRITE) begin
      if (j_r.cmd) begin
        out_r <= {(in_rng_w && rd_r[RW]),
                  (in_rng_w && rd_r[RW]) ? rd_r[RW-1:0] : RW'(0),
                  BIW'(0), RW'(0), 1'b0};
      end else begin
        out_r <= {1'b0, RW'(0), j_r.bin, j_r.range, j_r.pass && output_mode[0]};
      end
    end
  end
endmodule

/* rtl/core/point_polar_filter_min_binning.sv */
// Channel | Dir | Content
// s_axis  | in  | tuser: command; tdata: point_x, point_y, origin_x, origin_y, read_index
// m_axis  | out | tdata: accepted, point_range, point_bin, bin_value, bin_filled
// cfg     | in  | register index and write data, always ready
// A point holds the front end after acceptance for 21 square root steps,
// CORDIC_STEPS CORDIC steps (a single pass with no rotation for a zero offset or the angle
// of plus pi), one multiply, one bin limit and one handoff; the front end takes the next
// request only once it is idle again. A read request goes straight to the handoff.
// The back end takes one request at a time through its read, write and output states.
// Reset is synchronous, active low; the back end then empties all 1024 bins
// before it takes a request. A held result stalls the back end, and
// once the two-entry queue is full, the front end.
`include "point_polar_filter_min_binning_assert.svh"
module point_polar_filter_min_binning import ppf_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // command[0]
  input  logic s_axis_tuser,
  // point_x[19:0], point_y[39:20], origin_x[59:40], origin_y[79:60],
  // read_index[89:80]
  input  logic [95:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // accepted[0], point_range[20:1], point_bin[30:21], bin_value[50:31],
  // bin_filled[51]
  output logic [55:0] m_axis_tdata,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data
);
  logic [RW-1:0] min_range_r, max_range_r;
  logic signed [CW-1:0] min_x_r, max_x_r, min_y_r, max_y_r;
  logic [10:0] bin_count_r;
  logic [1:0] mode_r;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_range_r <= 20'd51; max_range_r <= 20'd10240;
      min_x_r <= -20'sd10240; max_x_r <= 20'sd10240;
      min_y_r <= -20'sd10240; max_y_r <= 20'sd10240;
      bin_count_r <= 11'd1000; mode_r <= 2'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MIN_RANGE: min_range_r <= cfg_data[19:0];
        REG_MAX_RANGE: max_range_r <= cfg_data[19:0];
        REG_MIN_X: min_x_r <= cfg_data[19:0];
        REG_MAX_X: max_x_r <= cfg_data[19:0];
        REG_MIN_Y: min_y_r <= cfg_data[19:0];
        REG_MAX_Y: max_y_r <= cfg_data[19:0];
        REG_BIN_COUNT: bin_count_r <= cfg_data[10:0];
        REG_OUT_MODE: mode_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic fv, fr, qv, qr;
  job_t fj, qj;
  logic [51:0] od;
  assign m_axis_tdata = {4'd0, od};

  ppf_front #(.CORDIC_STEPS(CORDIC_STEPS)) u_front (
    .clk, .rst_n, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .cmd(s_axis_tuser), .px(s_axis_tdata[19:0]), .py(s_axis_tdata[39:20]),
    .ox(s_axis_tdata[59:40]), .oy(s_axis_tdata[79:60]),
    .read_index(s_axis_tdata[89:80]),
    .min_range(min_range_r), .max_range(max_range_r),
    .min_x(min_x_r), .max_x(max_x_r), .min_y(min_y_r), .max_y(max_y_r),
    .bin_count(bin_count_r), .job_valid(fv), .job_ready(fr), .job(fj));

  ppf_queue u_queue (.clk, .rst_n, .wr_valid(fv), .wr_ready(fr), .wr_data(fj),
    .rd_valid(qv), .rd_ready(qr), .rd_data(qj));

  ppf_back u_back (.clk, .rst_n, .job_valid(qv),
    .job_ready(qr), .job(qj), .output_mode(mode_r), .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready), .out_data(od));

  `PPF_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `PPF_ASSERT_IMPL(a_read_no_range, clk, rst_n, m_axis_tvalid && od[51], od[20:1] == 20'd0)
endmodule

/* sim/point_polar_filter_min_binning_checker.sv */
// Watches the three channels of the polar point filter, predicts each result
// and compares it with the one the block delivers.
module point_polar_filter_min_binning_checker import ppf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // command[0]
  input  logic        s_axis_tuser,
  // point_x[19:0], point_y[39:20], origin_x[59:40], origin_y[79:60],
  // read_index[89:80]
  input  logic [95:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // accepted[0], point_range[20:1], point_bin[30:21], bin_value[50:31],
  // bin_filled[51]
  input  logic [55:0] m_axis_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBINS = 1024;
  localparam int STEPS = 16;
  localparam longint unsigned FULL_TURN = 64'h1_0000_0000;
  localparam longint unsigned SAT_TOP = (64'd1 << CW) - 1;

  typedef struct packed {
    logic            accepted;
    logic [RW-1:0]   point_range;
    logic [BIW-1:0]  point_bin;
    logic [RW-1:0]   bin_value;
    logic            bin_filled;
  } filter_result_t;

  // Binary-angle arctangent steps, 2^32 per turn.
  localparam longint ANGLE_STEP [0:15] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C
  };

  // Shadow of the configuration and the bin store.
  logic [RW-1:0]        lim_rmin, lim_rmax;
  logic signed [CW-1:0] lim_xmin, lim_xmax, lim_ymin, lim_ymax;
  logic [10:0]          n_bins_reg;
  logic [1:0]           mode_reg;
  logic [RW-1:0]        shadow_min [NBINS];
  logic                 shadow_full [NBINS];

  filter_result_t result_q [$];

  // Integer square root, floor.
  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Angle plus pi from CORDIC vectoring, clamped to one turn.
  function automatic longint unsigned polar_phase(input longint dx, input longint dy);
    longint x, y, z, t;
    if (dx == 0 && dy == 0) return 64'd1 << 31;
    if (dy == 0 && dx < 0) return FULL_TURN;
    x = dx * (64'sd1 << 24);
    y = dy * (64'sd1 << 24);
    z = 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 64'sd1 << 30;
      end else begin
        x = -y; y = t; z = -(64'sd1 << 30);
      end
    end
    for (int i = 0; i < STEPS; i++) begin
      t = x;
      if (y >= 0) begin
        x += y >>> i; y -= t >>> i; z += ANGLE_STEP[i];
      end else begin
        x -= y >>> i; y += t >>> i; z -= ANGLE_STEP[i];
      end
    end
    z += 64'sd1 << 31;
    if (z < 0) return 0;
    if (longint'(z) > longint'(FULL_TURN)) return FULL_TURN;
    return z;
  endfunction

  // Works out one result and updates the shadow bin store.
  function automatic filter_result_t filter_point(input logic cmd, input logic [95:0] req);
    filter_result_t res;
    longint dx, dy;
    longint unsigned ax, ay, r, cnt, bin;
    logic [BIW-1:0] idx;
    bit pass;
    res = '0;
    if (cmd) begin
      idx = req[89:80];
      res.bin_value  = shadow_full[idx] ? shadow_min[idx] : '0;
      res.bin_filled = shadow_full[idx];
      shadow_full[idx] = 1'b0;
      shadow_min[idx] = '0;
      return res;
    end
    dx = longint'($signed(req[19:0])) - longint'($signed(req[59:40]));
    dy = longint'($signed(req[39:20])) - longint'($signed(req[79:60]));
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    r = root_floor(ax * ax + ay * ay);
    cnt = n_bins_reg;
    if (cnt < 2) cnt = 2;
    if (cnt > NBINS) cnt = NBINS;
    bin = (polar_phase(dx, dy) * cnt) >> 32;
    if (bin >= cnt) bin = cnt - 1;
    pass = dx > lim_xmin && dx < lim_xmax && dy > lim_ymin && dy < lim_ymax &&
           r > lim_rmin && r < lim_rmax;
    if (r > SAT_TOP) r = SAT_TOP;
    if (pass && mode_reg[1]) begin
      if (!shadow_full[bin] || r < shadow_min[bin]) begin
        shadow_min[bin] = r[RW-1:0];
        shadow_full[bin] = 1'b1;
      end
    end
    res.accepted    = pass && mode_reg[0];
    res.point_range = r[RW-1:0];
    res.point_bin   = bin[BIW-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    filter_result_t want, got, pred;
    if (!rst_n) begin
      lim_rmin <= 20'd51;
      lim_rmax <= 20'd10240;
      lim_xmin <= -20'sd10240;
      lim_xmax <= 20'sd10240;
      lim_ymin <= -20'sd10240;
      lim_ymax <= 20'sd10240;
      n_bins_reg <= 11'd1000;
      mode_reg <= 2'd1;
      for (int i = 0; i < NBINS; i++) shadow_full[i] = 1'b0;
      result_q.delete();
      fail_count = 0;
    end else begin
      // The user must write registers only while the block is idle; the block itself does not enforce this.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MIN_RANGE: lim_rmin <= cfg_data[RW-1:0];
          REG_MAX_RANGE: lim_rmax <= cfg_data[RW-1:0];
          REG_MIN_X:     lim_xmin <= cfg_data[CW-1:0];
          REG_MAX_X:     lim_xmax <= cfg_data[CW-1:0];
          REG_MIN_Y:     lim_ymin <= cfg_data[CW-1:0];
          REG_MAX_Y:     lim_ymax <= cfg_data[CW-1:0];
          REG_BIN_COUNT: n_bins_reg <= cfg_data[10:0];
          REG_OUT_MODE:  mode_reg <= cfg_data[1:0];
          default: ;
        endcase
      end
      // A delivered result always belongs to the oldest request.
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[0], m_axis_tdata[20:1], m_axis_tdata[30:21],
               m_axis_tdata[50:31], m_axis_tdata[51]};
        if (result_q.size() == 0) begin
          $error("result with no request outstanding: %h", m_axis_tdata);
          fail_count++;
        end else begin
          want = result_q.pop_front();
          if (got.accepted !== want.accepted) begin
            $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
            fail_count++;
          end
          if (got.point_range !== want.point_range) begin
            $error("point_range: expected %0d, got %0d", want.point_range, got.point_range);
            fail_count++;
          end
          if (got.point_bin !== want.point_bin) begin
            $error("point_bin: expected %0d, got %0d", want.point_bin, got.point_bin);
            fail_count++;
          end
          if (got.bin_value !== want.bin_value) begin
            $error("bin_value: expected %0d, got %0d", want.bin_value, got.bin_value);
            fail_count++;
          end
          if (got.bin_filled !== want.bin_filled) begin
            $error("bin_filled: expected %0d, got %0d", want.bin_filled, got.bin_filled);
            fail_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pred = filter_point(s_axis_tuser, s_axis_tdata);
        result_q.insert(result_q.size(), pred);
      end
    end
    pending_count = result_q.size();
  end
endmodule

/* sim/point_polar_filter_min_binning_test.sv */
module point_polar_filter_min_binning_test import ppf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_user = 1'b0;
  logic [95:0] in_data = '0;
  logic        out_ready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [2:0]  cfg_index = REG_MIN_RANGE;
  logic [31:0] cfg_data = '0;
  logic        s_axis_tready, m_axis_tvalid, cfg_ready;
  logic [55:0] m_axis_tdata;
  int          fail_count, pending_count;

  bit quiet = 1'b0;
  int stall_left = 0;
  int n_points = 0, n_reads = 0;
  int bins_now = 1000;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  point_polar_filter_min_binning u_top (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(in_valid), .s_axis_tready(s_axis_tready), .s_axis_tuser(in_user),
    .s_axis_tdata(in_data),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(out_ready), .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  point_polar_filter_min_binning_checker u_check (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(in_valid), .s_axis_tready(s_axis_tready), .s_axis_tuser(in_user),
    .s_axis_tdata(in_data),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(out_ready), .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // Receiver stalls in random bursts, none in the quiet stretch.
  always @(posedge clk) begin
    if (quiet) begin
      out_ready <= 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if ($urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(0, 11);
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    #2ms;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_req(input bit cmd, input logic [CW-1:0] px, input logic [CW-1:0] py,
                          input logic [CW-1:0] ox, input logic [CW-1:0] oy,
                          input logic [BIW-1:0] ri);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_user <= cmd;
    in_data <= {6'b0, ri, oy, ox, py, px};
    in_valid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    if (cmd) n_reads++;
    else n_points++;
  endtask

  task automatic send_point(input logic [CW-1:0] px, input logic [CW-1:0] py,
                            input logic [CW-1:0] ox, input logic [CW-1:0] oy);
    send_req(1'b0, px, py, ox, oy, BIW'($urandom));
  endtask

  task automatic send_read(input logic [BIW-1:0] ri);
    send_req(1'b1, CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom), ri);
  endtask

  // Stops sending and waits for every outstanding result.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_BIN_COUNT) begin
      bins_now = int'(val[10:0]);
      if (bins_now < 2) bins_now = 2;
      if (bins_now > 1024) bins_now = 1024;
    end
  endtask

  task automatic write_limits(input int rmin, input int rmax, input int xmin, input int xmax,
                              input int ymin, input int ymax);
    write_reg(REG_MIN_RANGE, rmin);
    write_reg(REG_MAX_RANGE, rmax);
    write_reg(REG_MIN_X, xmin);
    write_reg(REG_MAX_X, xmax);
    write_reg(REG_MIN_Y, ymin);
    write_reg(REG_MAX_Y, ymax);
  endtask

  // Mostly plausible scan points near a sensor, some raw noise, some bin reads.
  task automatic random_traffic(input int n);
    int kind, ox, oy, dx, dy, span;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
        ox = $urandom_range(0, 200000) - 100000;
        oy = $urandom_range(0, 200000) - 100000;
        span = ($urandom_range(0, 3) == 0) ? 200 : 14000;
        dx = $urandom_range(0, 2 * span) - span;
        dy = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(0, 2 * span) - span;
        send_point(CW'(ox + dx), CW'(oy + dy), CW'(ox), CW'(oy));
      end else if (kind < 78) begin
        send_point(CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom));
      end else if (kind < 96) begin
        send_read(BIW'($urandom_range(0, bins_now - 1)));
      end else begin
        send_read(BIW'($urandom));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed points under the reset settings: extremes, zero offset, angle of plus pi.
    send_point(20'sd524287, 20'sd524287, -20'sd524288, -20'sd524288);
    send_point(-20'sd524288, -20'sd524288, 20'sd524287, 20'sd524287);
    send_point(20'sd524287, -20'sd524288, -20'sd524288, 20'sd524287);
    send_point(20'sd100, 20'sd100, 20'sd100, 20'sd100);
    send_point(-20'sd500, 20'sd7, 20'sd0, 20'sd7);
    send_point(20'sd500, 20'sd0, 20'sd0, 20'sd0);
    send_point(20'sd0, 20'sd500, 20'sd0, 20'sd0);
    send_point(20'sd0, -20'sd500, 20'sd0, 20'sd0);
    send_point(20'sd51, 20'sd0, 20'sd0, 20'sd0);
    send_point(20'sd52, 20'sd0, 20'sd0, 20'sd0);
    send_point(20'sd10239, 20'sd0, 20'sd0, 20'sd0);
    send_point(-20'sd10239, -20'sd1, 20'sd0, 20'sd0);
    send_read(10'd0);
    send_read(10'd1023);
    drain();

    // Binning on: fill some bins, including the plus pi bin, and read them back.
    write_reg(REG_OUT_MODE, 32'd3);
    send_point(-20'sd300, 20'sd0, 20'sd0, 20'sd0);
    send_point(-20'sd200, 20'sd0, 20'sd0, 20'sd0);
    send_point(-20'sd250, 20'sd0, 20'sd0, 20'sd0);
    send_point(20'sd400, 20'sd10, 20'sd0, 20'sd0);
    send_read(10'd999);
    send_read(10'd999);
    send_read(10'd500);
    send_read(10'd501);
    drain();

    // Small bin set with the receiver stalling.
    write_reg(REG_BIN_COUNT, 32'd8);
    random_traffic(100);
    // Hold off once until everything has come back, then continue.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    random_traffic(20);
    drain();

    // Widest settings: every limit at its extreme, all bins.
    write_limits(0, 1048575, -524288, 524287, -524288, 524287);
    write_reg(REG_BIN_COUNT, 32'd1024);
    random_traffic(130);
    drain();

    // Two bins, binning only.
    write_reg(REG_BIN_COUNT, 32'd2);
    write_reg(REG_OUT_MODE, 32'd2);
    write_limits(1000, 5000, -6000, 6000, -3000, 3000);
    random_traffic(110);
    drain();

    // Bin count below range, everything off.
    write_reg(REG_BIN_COUNT, 32'd0);
    write_reg(REG_OUT_MODE, 32'd0);
    random_traffic(80);
    drain();

    // Bin count above range, tight box.
    write_reg(REG_BIN_COUNT, 32'd2047);
    write_reg(REG_OUT_MODE, 32'd3);
    write_limits(10, 12000, -2000, 9000, -9000, 2000);
    random_traffic(120);
    drain();

    // Last stretch at full rate, no idling on either side.
    write_reg(REG_BIN_COUNT, 32'd360);
    write_reg(REG_OUT_MODE, 32'd1);
    write_limits(51, 10240, -10240, 10240, -10240, 10240);
    quiet = 1'b1;
    random_traffic(150);
    drain();

    $display("Covered %0d points and %0d bin reads over eight register settings,",
             n_points, n_reads);
    $display("bin counts from clamped low to clamped high, with random stalls on both sides.");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
